### sv/dual_pi_deadband_drive_mixer_top_assert.svh
// ----------------------------------------------------------------------------
// dual_pi_deadband_drive_mixer_top_assert
// Assertion macros for the drive mixer block.
// ----------------------------------------------------------------------------
`ifndef DUAL_PI_DEADBAND_DRIVE_MIXER_TOP_ASSERT_SVH
`define DUAL_PI_DEADBAND_DRIVE_MIXER_TOP_ASSERT_SVH

// Implication checked on the next clock edge after the antecedent.
`define DPDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked in the same clock edge as the antecedent.
`define DPDM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/dpdm_pkg.sv
// ----------------------------------------------------------------------------
// dpdm_pkg
// Shared types and constants of the dual PI drive mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dpdm_pkg;
	localparam int GAIN_FRAC = 8;
	localparam int INT_EXTRA = 12;
	localparam int MUL_BW    = 16;
	localparam int DRV_W     = 12;
	localparam int WHEEL_W   = 9;
	localparam int CFG_W     = 16;
	localparam int CFG_AW    = 3;
	localparam int OP_W      = 3;

	typedef enum logic [CFG_AW-1:0] {
		CFG_DIST_GAIN  = 3'd0,
		CFG_ANGLE_GAIN = 3'd1,
		CFG_INT_FACTOR = 3'd2,
		CFG_DEADBAND   = 3'd3,
		CFG_WHEEL_OFS  = 3'd4,
		CFG_WHEEL_THR  = 3'd5,
		CFG_SMOOTH_SH  = 3'd6,
		CFG_UNUSED     = 3'd7
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_NONE       = 3'd0,
		OP_TOGGLE     = 3'd1,
		OP_DIST_UP    = 3'd2,
		OP_DIST_DOWN  = 3'd3,
		OP_ANGLE_UP   = 3'd4,
		OP_ANGLE_DOWN = 3'd5,
		OP_RSVD6      = 3'd6,
		OP_RSVD7      = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ERR,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_MIX
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mul_ctl_t;
endpackage
`default_nettype wire

### sv/dpdm_mul.sv
// ----------------------------------------------------------------------------
// dpdm_mul
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dpdm_mul import dpdm_pkg::*; #(
	parameter int AW = 50
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [AW-1:0] a,
	input  wire logic [MUL_BW-1:0]    b,
	output logic                      busy,
	output logic                      done,
	output logic signed [AW-1:0]      prod
);
	localparam int CW = $clog2(MUL_BW + 1);

	logic signed [AW-1:0] acc_q, a_q;
	logic [MUL_BW-1:0]    b_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MUL_BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

### sv/dual_pi_deadband_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// dual_pi_deadband_drive_mixer_top
// Two PI loops with error deadband, sample smoothing and wheel mixing.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream s_*: one word per control tick. tdata carries distance_sample
//  (low bits) then angle_sample; tuser carries the key operation.
//  Output stream m_*: one word per tick with both wheel commands, both loop
//  drives and the auto mode flag.
//  Config port cfg_*: write gains, integral factor, deadband, wheel offset,
//  threshold and smoothing shift while the block is idle.
// Sequence:
//  In manual mode a tick passes through prepare, one error step per loop, mix
//  and back to idle. In auto mode it passes through prepare, then for each
//  loop an error step and three serial multiplies on the bit-serial
//  multiplier, then mix and idle. One tick is in work at a time; s_tready
//  is high only while idle.
// Reset:
//  Asynchronous arst_n restores register defaults, setpoints 180 and 18,
//  clears filters, integrals, held drives, auto mode and priming.
// Stall:
//  The result sits in an output register; a new tick is taken while it
//  waits, and its result is held back until m_tready drains the old one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dual_pi_deadband_drive_mixer_top_assert.svh"
module dual_pi_deadband_drive_mixer_top import dpdm_pkg::*; #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_AW-1:0]     cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// distance_sample, angle_sample, zero fill
	input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	// operation
	input  wire logic [OP_W-1:0]       s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// left_wheel, right_wheel, distance_drive, angle_drive, auto_active, zero fill
	output logic [47:0]                m_tdata
);
	localparam int SW  = SAMPLE_WIDTH;
	localparam int AW  = SW + 34;
	localparam int IW  = FRACTION_BITS + INT_EXTRA + 8;
	localparam int LW  = SW + 1;
	localparam logic signed [AW-1:0] SMAX = AW'((64'sd1 <<< (SW - 1)) - 1);
	localparam logic signed [AW-1:0] SMIN = -SMAX - 1;
	localparam logic signed [AW-1:0] WRAP = AW'(64'sd359 <<< FRACTION_BITS);
	localparam logic signed [AW-1:0] DSTEP = AW'(64'sd5 <<< FRACTION_BITS);
	localparam logic signed [AW-1:0] ASTEP = AW'(64'sd1 <<< FRACTION_BITS);
	localparam logic signed [AW-1:0] LIM = AW'(64'sd100 <<< FRACTION_BITS);
	localparam logic signed [AW-1:0] ILIM = AW'(64'sd100 <<< (FRACTION_BITS + INT_EXTRA));
	localparam logic signed [AW-1:0] SP_D0 = AW'(64'sd180 <<< FRACTION_BITS);
	localparam logic signed [AW-1:0] SP_A0 = AW'(64'sd18 <<< FRACTION_BITS);

	// configuration
	logic [11:0] dgain_q, again_q;
	logic [15:0] ifac_q;
	logic [7:0]  db_q;
	logic [10:0] wofs_q, wthr_q;
	logic [2:0]  ssh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dgain_q <= 12'd973;
			again_q <= 12'd128;
			ifac_q  <= 16'd655;
			db_q    <= 8'd8;
			wofs_q  <= 11'd400;
			wthr_q  <= 11'd40;
			ssh_q   <= 3'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_DIST_GAIN:  dgain_q <= cfg_wdata[11:0];
				CFG_ANGLE_GAIN: again_q <= cfg_wdata[11:0];
				CFG_INT_FACTOR: ifac_q  <= cfg_wdata;
				CFG_DEADBAND:   db_q    <= cfg_wdata[7:0];
				CFG_WHEEL_OFS:  wofs_q  <= cfg_wdata[10:0];
				CFG_WHEEL_THR:  wthr_q  <= cfg_wdata[10:0];
				CFG_SMOOTH_SH:  ssh_q   <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// tick and loop state
	state_t state_q, state_d;
	logic                 li_q;
	logic [OP_W-1:0]      op_q;
	logic signed [SW-1:0] samp_q [2];
	logic signed [SW-1:0] filt_q [2];
	logic signed [SW-1:0] sp_q   [2];
	logic signed [LW-1:0] last_q [2];
	logic signed [IW-1:0] integ_q[2];
	logic signed [DRV_W-1:0] held_q[2];
	logic signed [LW-1:0] e_q;
	logic signed [AW-1:0] p_q;
	logic                 auto_q, primed_q;
	logic                 m_tvalid_q;
	logic [47:0]          m_tdata_q;

	logic                 mul_start, mul_busy, mul_done;
	logic signed [AW-1:0] mul_a, mul_p;
	logic [MUL_BW-1:0]    mul_b;

	dpdm_mul #(.AW(AW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_p)
	);

	// error with deadband for the current loop
	logic signed [AW-1:0] ew, e_c, dbx;
	logic [MUL_BW-1:0]    gain_c;
	always_comb begin
		dbx = AW'($signed({1'b0, db_q}));
		ew  = AW'(sp_q[li_q]) - AW'(filt_q[li_q]);
		if (ew > dbx)
			e_c = ew - dbx;
		else if (ew < -dbx)
			e_c = ew + dbx;
		else
			e_c = '0;
		gain_c = li_q ? MUL_BW'(again_q) : MUL_BW'(dgain_q);
	end

	// integral and drive update after the last multiply
	logic signed [AW-1:0] ui, u, uc, ic;
	always_comb begin
		ui = AW'(integ_q[li_q]) + (mul_p >>> INT_EXTRA);
		u  = p_q + (ui >>> INT_EXTRA);
		uc = (u > LIM) ? LIM : ((u < -LIM) ? -LIM : u);
		ic = (ui > ILIM) ? ILIM : ((ui < -ILIM) ? -ILIM : ui);
	end

	// next state and multiplier control
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = AW'(e_c);
		mul_b     = gain_c;
		s_tready  = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_PREP;
			ST_PREP: state_d = ST_ERR;
			ST_ERR: begin
				if (auto_q) begin
					mul_start = 1'b1;
					state_d   = ST_M1;
				end else if (li_q) begin
					state_d = ST_MIX;
				end
			end
			ST_M1: begin
				mul_a = AW'(last_q[li_q]);
				if (mul_done) begin
					mul_start = 1'b1;
					state_d   = ST_M2;
				end
			end
			ST_M2: begin
				mul_a = mul_p;
				mul_b = ifac_q;
				if (mul_done) begin
					mul_start = 1'b1;
					state_d   = ST_M3;
				end
			end
			ST_M3: begin
				if (mul_done)
					state_d = li_q ? ST_MIX : ST_ERR;
			end
			ST_MIX: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// setpoint steps and smoothing
	logic [2:0]           sh_c;
	logic signed [AW-1:0] dsp_c, asp_c, t_c;
	logic signed [SW-1:0] fnew [2];
	always_comb begin
		sh_c  = (ssh_q > 3'd4) ? 3'd4 : ssh_q;
		dsp_c = AW'(sp_q[0]);
		asp_c = AW'(sp_q[1]);
		t_c   = '0;
		unique case (op_t'(op_q))
			OP_DIST_UP: begin
				t_c   = AW'(sp_q[0]) + DSTEP;
				if (t_c > WRAP) t_c = t_c - WRAP;
				dsp_c = (t_c > SMAX) ? SMAX : ((t_c < SMIN) ? SMIN : t_c);
			end
			OP_DIST_DOWN: begin
				t_c   = AW'(sp_q[0]) - DSTEP;
				if (t_c < 0) t_c = t_c + WRAP;
				dsp_c = (t_c > SMAX) ? SMAX : ((t_c < SMIN) ? SMIN : t_c);
			end
			OP_ANGLE_UP: begin
				t_c   = AW'(sp_q[1]) + ASTEP;
				asp_c = (t_c > SMAX) ? SMAX : t_c;
			end
			OP_ANGLE_DOWN: begin
				t_c   = AW'(sp_q[1]) - ASTEP;
				asp_c = (t_c < SMIN) ? SMIN : t_c;
			end
			default: ;
		endcase
		for (int k = 0; k < 2; k++) begin
			logic signed [SW:0] fo, df;
			fo = primed_q ? (SW+1)'(filt_q[k]) : (SW+1)'(samp_q[k]);
			df = (SW+1)'(samp_q[k]) - fo;
			fnew[k] = SW'(fo + (df >>> sh_c));
		end
	end

	// wheel mixing
	function automatic logic signed [WHEEL_W-1:0] mix_wheel(
		input logic signed [DRV_W+1:0] x,
		input logic [10:0]             thr,
		input logic [10:0]             ofs
	);
		logic signed [DRV_W+2:0] v, mag, r;
		v   = (DRV_W+3)'(x);
		mag = (v < 0) ? -v : v;
		if (mag > (DRV_W+3)'($signed({1'b0, thr})))
			v = (v >= 0) ? v + (DRV_W+3)'($signed({1'b0, ofs}))
			             : v - (DRV_W+3)'($signed({1'b0, ofs}));
		r = (v >= 0) ? (v >>> FRACTION_BITS) : -((-v) >>> FRACTION_BITS);
		if (r > 255) r = 255;
		if (r < -255) r = -255;
		return WHEEL_W'(r);
	endfunction

	logic signed [DRV_W+1:0] lmix, rmix;
	assign lmix = -(DRV_W+2)'(held_q[0]) + (DRV_W+2)'(held_q[1]);
	assign rmix = -(DRV_W+2)'(held_q[0]) - (DRV_W+2)'(held_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			li_q       <= 1'b0;
			auto_q     <= 1'b0;
			primed_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			sp_q[0]    <= SW'(SP_D0);
			sp_q[1]    <= SW'(SP_A0);
			for (int k = 0; k < 2; k++) begin
				filt_q[k]  <= '0;
				last_q[k]  <= '0;
				integ_q[k] <= '0;
				held_q[k]  <= '0;
			end
		end else begin
			// load a new word, or drop the old one once it is taken
			if (state_q == ST_MIX && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: li_q <= 1'b0;
				ST_PREP: begin
					// apply key, prime and smooth
					if (op_t'(op_q) == OP_TOGGLE) auto_q <= !auto_q;
					sp_q[0]   <= SW'(dsp_c);
					sp_q[1]   <= SW'(asp_c);
					filt_q[0] <= fnew[0];
					filt_q[1] <= fnew[1];
					primed_q  <= 1'b1;
				end
				ST_ERR: begin
					if (!auto_q) begin
						// manual: track measurement, hold drive
						sp_q[li_q]    <= filt_q[li_q];
						last_q[li_q]  <= '0;
						integ_q[li_q] <= IW'(AW'(held_q[li_q]) <<< INT_EXTRA);
						li_q          <= 1'b1;
					end
				end
				ST_M3: begin
					if (mul_done) begin
						integ_q[li_q] <= IW'(ic);
						held_q[li_q]  <= DRV_W'(uc);
						last_q[li_q]  <= e_q;
						li_q          <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= s_tuser;
			samp_q[0] <= s_tdata[SW-1:0];
			samp_q[1] <= s_tdata[2*SW-1:SW];
		end
		if (state_q == ST_ERR)
			e_q <= LW'(e_c);
		if (state_q == ST_M1 && mul_done)
			p_q <= mul_p >>> GAIN_FRAC;
		if (state_q == ST_MIX && (!m_tvalid_q || m_tready))
			m_tdata_q <= {5'b0, auto_q, held_q[1], held_q[0],
			              mix_wheel(rmix, wthr_q, wofs_q),
			              mix_wheel(lmix, wthr_q, wofs_q)};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	logic signed [DRV_W-1:0] ddrv_mon;
	assign ddrv_mon = m_tdata[29:18];

	`DPDM_ASSERT_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready, "tick accepted while busy")
	`DPDM_ASSERT_SAME(a_mul_idle, state_q == ST_IDLE, !mul_busy, "multiplier busy when idle")
	`DPDM_ASSERT_SAME(a_drv_lim, m_tvalid, (ddrv_mon <= DRV_W'(LIM)) && (ddrv_mon >= -DRV_W'(LIM)), "drive out of range")
endmodule
`default_nettype wire
